@@ design/strobed_byte_line_transmitter_core_defines.svh @@
// ----------------------------------------------------------------------------
// Strobed byte line transmitter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STROBED_BYTE_LINE_TRANSMITTER_CORE_DEFINES_SVH
`define STROBED_BYTE_LINE_TRANSMITTER_CORE_DEFINES_SVH

// Same-cycle implication
`define SBLT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SBLT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/sblt_pkg.sv @@
// ----------------------------------------------------------------------------
// Strobed byte line transmitter package
// Widths, codes, register indexes and the result layout shared by the core
// and its checker.
// ----------------------------------------------------------------------------
package sblt_pkg;

    // Transaction operation codes (carried in tuser)
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    // Status codes reported in each result
    localparam logic [2:0] ST_OFFLINE    = 3'd0;
    localparam logic [2:0] ST_DELAY      = 3'd1;
    localparam logic [2:0] ST_WAIT_START = 3'd2;
    localparam logic [2:0] ST_SPR_LOW    = 3'd3;
    localparam logic [2:0] ST_SEND       = 3'd4;
    localparam logic [2:0] ST_ENDED      = 3'd5;
    localparam logic [2:0] ST_ERROR      = 3'd6;

    // Configuration register indexes
    localparam logic [2:0] REG_PRE_START   = 3'd0;
    localparam logic [2:0] REG_SPR_LOW     = 3'd1;
    localparam logic [2:0] REG_SPR_HIGH    = 3'd2;
    localparam logic [2:0] REG_END         = 3'd3;
    localparam logic [2:0] REG_TAIL_LEN    = 3'd4;
    localparam logic [2:0] REG_HEADER_LEN  = 3'd5;
    localparam logic [2:0] REG_RAW_MODE    = 3'd6;

    // Register reset values
    localparam logic [15:0] PRE_START_RST  = 16'd500;
    localparam logic [15:0] SPR_LOW_RST    = 16'd2;
    localparam logic [15:0] SPR_HIGH_RST   = 16'd2;
    localparam logic [15:0] END_RST        = 16'd2;
    localparam logic [7:0]  TAIL_LEN_RST   = 8'd10;
    localparam logic [7:0]  HEADER_LEN_RST = 8'd50;

    // Port widths
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 32;

    // One result, last field in the lowest bits
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] sent_count;
        logic        byte_taken;
        logic        busy_level;
        logic        sprocket_level;
        logic        strobe_res;
        logic [7:0]  data_out;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    // Odd parity over the low seven bits, placed in bit 7
    function automatic logic [7:0] odd_parity7(input logic [7:0] v);
        return {~(^v[6:0]), v[6:0]};
    endfunction

endpackage

@@ design/strobed_byte_line_transmitter_core.sv @@
// ----------------------------------------------------------------------------
// Strobed byte line transmitter core
// Tick-driven sequencer for a parallel byte line with sprocket, strobe and
// ready/busy lines.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one transaction per timer tick or command. tuser holds the
//   operation (tick, start, stop); tdata holds the start/stop line level, the
//   source byte valid flag and the source byte.
//   m_axis returns exactly one result per input transaction: the data lines,
//   strobe, sprocket, busy, byte taken flag, sent byte count and status.
//   cfg_we/cfg_addr/cfg_data write the timing and length registers; write
//   them only while the block is idle.
// Timing:
//   Each transaction is handled in a single pass of logic between the state
//   registers and the output stage, where its result is registered; one
//   transaction can be accepted every cycle while s_axis_tready is high.
// Reset and stall:
//   Reset puts the line offline with busy and sprocket high and restores the
//   register defaults. A two-entry output stage (result register plus skid
//   register) lets one more transaction in while a result waits; with both
//   full, s_axis_tready drops until the receiver takes a result.
// ----------------------------------------------------------------------------
module strobed_byte_line_transmitter_core
    import sblt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: [0] start_level, [1] byte_valid, [9:2] byte_value, [15:10] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: [1:0] operation
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    // Result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: [7:0] data_out, [8] strobe_res, [9] sprocket_level,
    //        [10] busy_level, [11] byte_taken, [27:12] sent_count,
    //        [30:28] status, [31] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    typedef enum logic [2:0] {
        MODE_OFFLINE    = ST_OFFLINE,
        MODE_COUNTDOWN  = ST_DELAY,
        MODE_WAIT_START = ST_WAIT_START,
        MODE_SPR_LOW    = ST_SPR_LOW,
        MODE_SEND       = ST_SEND,
        MODE_ENDED      = ST_ENDED,
        MODE_ERROR      = ST_ERROR
    } mode_t;

    // Zero-length delays act as one tick
    function automatic logic [15:0] clamp_ticks(input logic [15:0] t);
        return (t == 16'd0) ? 16'd1 : t;
    endfunction

    // Configuration registers
    logic [15:0] pre_start_reg;
    logic [15:0] spr_low_reg;
    logic [15:0] spr_high_reg;
    logic [15:0] end_reg;
    logic [7:0]  tail_len_reg;
    logic [7:0]  header_len_reg;
    logic        raw_mode_reg;

    // Sequencer state
    mode_t       mode_reg, mode_next;
    mode_t       maw_reg, maw_next;
    logic [15:0] delay_reg, delay_next;
    logic [7:0]  header_left_reg, header_left_next;
    logic [7:0]  tail_left_reg, tail_left_next;
    logic [15:0] sent_reg, sent_next;
    logic        sprocket_reg, sprocket_next;
    logic        busy_reg, busy_next;
    logic [7:0]  data_reg, data_next;

    // Output stage
    logic        out_valid_reg;
    logic        skid_valid_reg;
    result_t     out_reg;
    result_t     skid_reg;
    result_t     result;

    logic        in_fire;
    logic        out_free;
    logic        start_level;
    logic        byte_valid;
    logic [7:0]  byte_value;
    logic        strobe;
    logic        taken;
    logic        act_en;
    mode_t       act_mode;
    logic        have_byte;
    logic [7:0]  send_data;

    assign start_level = s_axis_tdata[0];
    assign byte_valid  = s_axis_tdata[1];
    assign byte_value  = s_axis_tdata[9:2];

    assign s_axis_tready = ~skid_valid_reg;
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign out_free      = ~out_valid_reg | m_axis_tready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_start_reg  <= PRE_START_RST;
            spr_low_reg    <= SPR_LOW_RST;
            spr_high_reg   <= SPR_HIGH_RST;
            end_reg        <= END_RST;
            tail_len_reg   <= TAIL_LEN_RST;
            header_len_reg <= HEADER_LEN_RST;
            raw_mode_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_PRE_START:  pre_start_reg  <= cfg_data;
                REG_SPR_LOW:    spr_low_reg    <= cfg_data;
                REG_SPR_HIGH:   spr_high_reg   <= cfg_data;
                REG_END:        end_reg        <= cfg_data;
                REG_TAIL_LEN:   tail_len_reg   <= cfg_data[7:0];
                REG_HEADER_LEN: header_len_reg <= cfg_data[7:0];
                REG_RAW_MODE:   raw_mode_reg   <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Next state for one transaction: an expiring delay hands over to its
    // target mode, which then acts in the same tick
    always_comb
    begin
        mode_next        = mode_reg;
        maw_next         = maw_reg;
        delay_next       = delay_reg;
        header_left_next = header_left_reg;
        tail_left_next   = tail_left_reg;
        sent_next        = sent_reg;
        sprocket_next    = sprocket_reg;
        busy_next        = busy_reg;
        data_next        = data_reg;
        strobe           = 1'b0;
        taken            = 1'b0;
        act_en           = 1'b0;
        act_mode         = mode_reg;
        have_byte        = 1'b0;
        send_data        = 8'd0;

        case (s_axis_tuser)
            OP_START:
            begin
                if (mode_reg == MODE_OFFLINE)
                begin
                    sent_next        = 16'd0;
                    header_left_next = raw_mode_reg ? 8'd0 : header_len_reg;
                    tail_left_next   = tail_len_reg;
                    busy_next        = 1'b1;
                    sprocket_next    = 1'b1;
                    maw_next         = MODE_WAIT_START;
                    delay_next       = clamp_ticks(pre_start_reg);
                    mode_next        = MODE_COUNTDOWN;
                end
            end
            OP_STOP:
            begin
                busy_next = 1'b1;
                mode_next = MODE_OFFLINE;
                maw_next  = MODE_OFFLINE;
            end
            OP_TICK:
            begin
                // Delay countdown
                if (mode_reg == MODE_COUNTDOWN)
                begin
                    if (delay_reg != 16'd0)
                    begin
                        delay_next = delay_reg - 16'd1;
                        if (delay_reg == 16'd1)
                        begin
                            mode_next = maw_reg;
                            act_mode  = maw_reg;
                            act_en    = 1'b1;
                        end
                    end
                    else
                    begin
                        mode_next = MODE_ERROR;
                    end
                end
                else
                begin
                    act_en = 1'b1;
                end

                if (act_en)
                begin
                    case (act_mode)
                        MODE_WAIT_START:
                        begin
                            if (start_level)
                            begin
                                busy_next  = 1'b0;
                                maw_next   = MODE_SPR_LOW;
                                delay_next = clamp_ticks(spr_low_reg);
                                mode_next  = MODE_COUNTDOWN;
                            end
                        end
                        MODE_SPR_LOW:
                        begin
                            sprocket_next = 1'b0;
                            maw_next      = MODE_SEND;
                            delay_next    = clamp_ticks(spr_low_reg);
                            mode_next     = MODE_COUNTDOWN;
                        end
                        MODE_SEND:
                        begin
                            // Header zero byte or source byte
                            if (!raw_mode_reg && header_left_reg != 8'd0)
                            begin
                                have_byte = 1'b1;
                                send_data = 8'd0;
                            end
                            else
                            begin
                                have_byte = byte_valid;
                                taken     = byte_valid;
                                if (byte_valid)
                                    send_data = raw_mode_reg ? byte_value
                                                             : odd_parity7(byte_value);
                            end
                            // Tail reload or wind-down
                            if (have_byte && start_level)
                                tail_left_next = tail_len_reg;
                            else if (tail_left_reg != 8'd0)
                                tail_left_next = tail_left_reg - 8'd1;
                            data_next     = send_data;
                            strobe        = 1'b1;
                            sprocket_next = 1'b1;
                            if (header_left_reg != 8'd0)
                                header_left_next = header_left_reg - 8'd1;
                            else
                                sent_next = sent_reg + 16'd1;
                            mode_next = MODE_COUNTDOWN;
                            if (tail_left_next == 8'd0)
                            begin
                                maw_next   = MODE_ENDED;
                                delay_next = clamp_ticks(end_reg);
                                busy_next  = 1'b1;
                            end
                            else
                            begin
                                maw_next   = MODE_SPR_LOW;
                                delay_next = clamp_ticks(spr_high_reg);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // Result as seen after this transaction
    always_comb
    begin
        result.data_out       = data_next;
        result.strobe_res     = strobe;
        result.sprocket_level = sprocket_next;
        result.busy_level     = busy_next;
        result.byte_taken     = taken;
        result.sent_count     = sent_next;
        result.status         = mode_next;
    end

    // Sequencer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_OFFLINE;
            maw_reg         <= MODE_OFFLINE;
            delay_reg       <= 16'd0;
            header_left_reg <= 8'd0;
            tail_left_reg   <= 8'd0;
            sent_reg        <= 16'd0;
            sprocket_reg    <= 1'b1;
            busy_reg        <= 1'b1;
            data_reg        <= 8'd0;
        end
        else if (in_fire)
        begin
            mode_reg        <= mode_next;
            maw_reg         <= maw_next;
            delay_reg       <= delay_next;
            header_left_reg <= header_left_next;
            tail_left_reg   <= tail_left_next;
            sent_reg        <= sent_next;
            sprocket_reg    <= sprocket_next;
            busy_reg        <= busy_next;
            data_reg        <= data_next;
        end
    end

    // Output stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output stage payload
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (in_fire)
                out_reg <= result;
        end
        else if (in_fire)
        begin
            skid_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-RESULT_W){1'b0}}, out_reg};

endmodule

@@ design/sblt_checker.sv @@
// ----------------------------------------------------------------------------
// Strobed byte line transmitter checker
// Port-level assertions on the input and result streams, bound to the core.
// ----------------------------------------------------------------------------
`include "strobed_byte_line_transmitter_core_defines.svh"

module sblt_checker
    import sblt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata
);

    result_t res;
    logic    stalled;
    logic    in_fire;
    logic    shown_strobe;
    logic    shown_taken;
    logic    shown_idle;

    assign res          = m_axis_tdata[RESULT_W-1:0];
    assign stalled      = m_axis_tvalid & ~m_axis_tready;
    assign in_fire      = s_axis_tvalid & s_axis_tready;
    assign shown_strobe = m_axis_tvalid & res.strobe_res;
    assign shown_taken  = m_axis_tvalid & res.byte_taken;
    assign shown_idle   = m_axis_tvalid
                        & ((res.status == ST_OFFLINE) || (res.status == ST_WAIT_START));

    // A held result stays put
    `SBLT_ASSERT_NEXT(a_hold_result, stalled, m_axis_tvalid && $stable(m_axis_tdata), "result moved")

    // Every strobe is followed by a delay phase
    `SBLT_ASSERT_IMPL(a_strobe_delay, shown_strobe, res.status == ST_DELAY, "strobe without delay")

    // A consumed source byte is always strobed out
    `SBLT_ASSERT_IMPL(a_taken_strobe, shown_taken, res.strobe_res, "byte taken without strobe")

    // Offline and waiting for start keep the line busy
    `SBLT_ASSERT_IMPL(a_idle_busy, shown_idle, res.busy_level, "not busy while idle")

    // After an accepted transaction, m_axis_tvalid is always high next cycle
    `SBLT_ASSERT_NEXT(a_result_follows, in_fire, m_axis_tvalid, "no result after transaction")

endmodule

bind strobed_byte_line_transmitter_core sblt_checker u_sblt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
